// ===== src/psort_pkg.sv =====
// ----------------------------------------------------------------------------
// psort_pkg: shared definitions for the partial selection sort block
// Sizes, command codes, the stored entry type and the control/status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package psort_pkg;

    localparam int MAX_ENTRIES = 32;                 // list depth
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int MOVE_W      = 6;
    localparam int SCORE_W     = 32;
    localparam int POS_W       = 6;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CMD_W       = 2;

    // stream payload widths
    localparam int S_DATA_W    = 48;                 // move, score, position, pad
    localparam int M_DATA_W    = 8;                  // best_move, pad

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd2;

    typedef struct packed {
        logic [MOVE_W-1:0]  move;
        logic [SCORE_W-1:0] score;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic append;     // write input entry at the tail
        logic clear;      // empty the list
        logic start;      // fetch hit: read position, arm scan
        logic step;       // scan: issue next read
        logic swap_wr;    // write position entry into best slot
        logic res_load;   // load output register (and write best into position)
        logic res_found;  // result carries a valid move
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;        // requested position below count
        logic scan_more;  // entries left to read
        logic rd_pend;    // read data in flight
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/partial_selection_sort_max.sv =====
// ----------------------------------------------------------------------------
// partial_selection_sort_max: move list with max-first selection
// Up to 32 (move, score) entries; append, clear and fetch-next-best commands.
//
// Input stream (s_axis): one transaction is one command. tuser carries the
// command (append, clear, fetch); tdata carries move, score and position.
// Append writes the entry at the tail (dropped when the list is full), clear
// empties the list; neither produces a result. Fetch scans from the given
// position to the tail, swaps the first entry with the highest score into
// the position and returns its move on m_axis with the found flag in tuser.
// A position at or past the count returns found = 0 and move 0.
//
// Timing: append, clear and unused codes are taken in the idle state, which the
// block does not leave for them. A fetch issues one read per cycle through the
// single read port of the entry memory, from the position to the tail, waits for
// the last read data to land, and then does the two swap writes: the position
// entry into the best slot, then the best entry into the position as the result
// register is loaded, which waits for the output slot. A missed fetch goes
// straight to loading the result. Items are processed one at a time;
// s_axis_tready is high only when idle.
//
// Reset (synchronous, active low) empties the list and drops any pending
// result. The result register holds while m_axis_tready is low; the block
// keeps taking appends and clears, and a later fetch waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module partial_selection_sort_max (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [5:0] move, [37:6] score, [43:38] position, [47:44] zero
    input  wire logic [psort_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  wire logic [psort_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [5:0] best_move, [7:6] zero
    output logic [psort_pkg::M_DATA_W-1:0]       m_axis_tdata,
    // [0] found
    output logic                                 m_axis_tuser
);
    import psort_pkg::*;

    logic [MOVE_W-1:0]  in_move;
    logic [SCORE_W-1:0] in_score;
    logic [POS_W-1:0]   in_pos;
    logic [MOVE_W-1:0]  best_move;
    t_dp_cmd            dp_cmd;
    t_dp_stat           dp_stat;

    // field unpack
    assign in_move  = s_axis_tdata[MOVE_W-1:0];
    assign in_score = s_axis_tdata[MOVE_W+SCORE_W-1:MOVE_W];
    assign in_pos   = s_axis_tdata[MOVE_W+SCORE_W+POS_W-1:MOVE_W+SCORE_W];

    psort_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_cmd       (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_stat      (dp_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_dp_cmd    (dp_cmd)
    );

    psort_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_move      (in_move),
        .i_score     (in_score),
        .i_pos       (in_pos),
        .o_stat      (dp_stat),
        .o_best_move (best_move),
        .o_found     (m_axis_tuser)
    );

    assign m_axis_tdata = M_DATA_W'(best_move);

endmodule

`default_nettype wire

// ===== src/psort_dp.sv =====
// ----------------------------------------------------------------------------
// psort_dp: list storage and scan datapath
// Entry memory with one write and one registered read port, entry count,
// scan index, running maximum and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psort_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire psort_pkg::t_dp_cmd            i_cmd,
    input  wire logic [psort_pkg::MOVE_W-1:0]  i_move,
    input  wire logic [psort_pkg::SCORE_W-1:0] i_score,
    input  wire logic [psort_pkg::POS_W-1:0]   i_pos,
    output psort_pkg::t_dp_stat                o_stat,
    output logic [psort_pkg::MOVE_W-1:0]       o_best_move,
    output logic                               o_found
);
    import psort_pkg::*;

    t_entry             mem [MAX_ENTRIES];

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_pos;
    logic [IDX_W-1:0]   r_best_idx;
    t_entry             r_best;
    t_entry             r_pos_entry;
    t_entry             r_rd_data;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_rd_vld;
    logic [MOVE_W-1:0]  r_out_move;
    logic               r_out_found;

    logic [CMP_W-1:0]   pos_ext;
    logic               full;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;

    assign pos_ext = CMP_W'(i_pos);
    assign full    = (r_count == CNT_W'(MAX_ENTRIES));

    assign o_stat.hit       = (pos_ext < CMP_W'(r_count));
    assign o_stat.scan_more = (r_idx < r_count);
    assign o_stat.rd_pend   = r_rd_vld;

    assign rd_en   = i_cmd.start || (i_cmd.step && o_stat.scan_more);
    assign rd_addr = i_cmd.start ? pos_ext[IDX_W-1:0] : r_idx[IDX_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IDX_W-1:0];
        wr_data = '{move: i_move, score: i_score};
        priority if (i_cmd.append && !full) begin
            wr_en = 1'b1;
        end else if (i_cmd.swap_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_best_idx;
            wr_data = r_pos_entry;
        end else if (i_cmd.res_load && i_cmd.res_found) begin
            wr_en   = 1'b1;
            wr_addr = r_pos;
            wr_data = r_best;
        end else begin
            wr_en = 1'b0;
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_idx  <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.append && !full) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // scan index, running maximum, first-greatest wins
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos <= pos_ext[IDX_W-1:0];
            r_idx <= CNT_W'(pos_ext[IDX_W-1:0]) + CNT_W'(1);
        end else if (i_cmd.step && o_stat.scan_more) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (r_rd_vld) begin
            if (r_rd_idx == r_pos) begin
                r_best      <= r_rd_data;
                r_best_idx  <= r_rd_idx;
                r_pos_entry <= r_rd_data;
            end else if ($signed(r_rd_data.score) > $signed(r_best.score)) begin
                r_best     <= r_rd_data;
                r_best_idx <= r_rd_idx;
            end
        end
        if (i_cmd.res_load) begin
            r_out_move  <= i_cmd.res_found ? r_best.move : '0;
            r_out_found <= i_cmd.res_found;
        end
    end

    assign o_best_move = r_out_move;
    assign o_found     = r_out_found;

endmodule

`default_nettype wire

// ===== src/psort_ctrl.sv =====
// ----------------------------------------------------------------------------
// psort_ctrl: command sequencer
// Decodes accepted transactions, steps the scan, orders the swap writes and
// owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module psort_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [psort_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic                          i_out_ready,
    input  wire psort_pkg::t_dp_stat           i_stat,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    output psort_pkg::t_dp_cmd                 o_dp_cmd
);
    import psort_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_SWAP   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_found, n_found;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_out_ready;
        o_dp_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        CMD_APPEND: o_dp_cmd.append = 1'b1;
                        CMD_CLEAR:  o_dp_cmd.clear  = 1'b1;
                        CMD_FETCH: begin
                            n_found = i_stat.hit;
                            if (i_stat.hit) begin
                                o_dp_cmd.start = 1'b1;
                                n_state        = S_SCAN;
                            end else begin
                                n_state = S_RESULT;
                            end
                        end
                        default: ;   // unused code: dropped
                    endcase
                end
            end
            S_SCAN: begin
                o_dp_cmd.step = 1'b1;
                if (!i_stat.scan_more && !i_stat.rd_pend) begin
                    n_state = S_SWAP;
                end
            end
            S_SWAP: begin
                o_dp_cmd.swap_wr = 1'b1;
                n_state          = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_dp_cmd.res_load  = 1'b1;
                    o_dp_cmd.res_found = r_found;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== src/psort_checker.sv =====
// ----------------------------------------------------------------------------
// psort_checker: port-level checks for partial_selection_sort_max
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module psort_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic [psort_pkg::CMD_W-1:0]     s_axis_tuser,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [psort_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  wire logic                            m_axis_tuser
);
    import psort_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // a null move reads as zero
    a_null_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("null result with nonzero move");

    // a fetch occupies the block for at least the next cycle
    a_fetch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_FETCH)) |=>
            !s_axis_tready)
        else $error("input taken right after a fetch");

    // a new result only comes out of a fetch in progress
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

    // result padding above the move reads zero
    a_data_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[M_DATA_W-1:MOVE_W] == '0))
        else $error("result padding not zero");

endmodule

bind partial_selection_sort_max psort_checker u_psort_checker (.*);

`default_nettype wire

// ===== sim/partial_selection_sort_max_tb.sv =====
// ----------------------------------------------------------------------------
// partial_selection_sort_max_tb: self-checking bench for the move list sorter
// Builds move lists with append/clear, pulls them out best-first with fetch,
// and checks every returned move and found flag against a model of the list
// kept in the bench. Bursty sender, stalling receiver, two long output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module partial_selection_sort_max_tb;

    import psort_pkg::*;

    localparam int CYCLE_LIMIT = 200000;  // far beyond the slowest legal run
    localparam int TAIL_CYCLES = 40;      // longer than one full 32-entry fetch
    localparam int ITEM_TARGET = 700;
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off

    // the one code the package leaves unnamed
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {SC_WIDE, SC_TIES, SC_EDGES} t_score_style;
    typedef enum int {RX_OPEN, RX_BUSY, RX_CHOKED} t_rx_mode;

    // one command transaction as the bench plans it
    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [POS_W-1:0]          position;
        bit                        drain;     // hold this item until all picks are back
    } t_cmd_item;

    // one fetch outcome
    typedef struct packed {
        logic [MOVE_W-1:0] move;
        logic              found;
    } t_pick;

    // ------------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_DATA_W-1:0]    s_axis_tdata  = '0;   // [5:0] move, [37:6] score,
                                                  // [43:38] position, [47:44] zero
    logic [CMD_W-1:0]       s_axis_tuser  = '0;   // [1:0] cmd
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_axis_tdata;         // [5:0] best_move, [7:6] zero
    logic                   m_axis_tuser;         // [0] found

    partial_selection_sort_max i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    int cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // ------------------------------------------------------------------------
    // List model: the bench's own copy of the entries and their count
    // ------------------------------------------------------------------------
    logic [MOVE_W-1:0]         list_move  [MAX_ENTRIES];
    logic signed [SCORE_W-1:0] list_score [MAX_ENTRIES];
    int                        list_len   = 0;

    t_cmd_item cmd_backlog[$];      // planned, not yet offered
    t_pick     expected_picks[$];   // predicted fetch outcomes, oldest first

    int n_planned    = 0;   // planned commands the block acts on
    int n_sent       = 0;   // transactions accepted on the input
    int n_fetch_acc  = 0;   // fetches accepted (each owes one result); driver only
    int n_res_seen   = 0;   // results accepted; monitor only, updated by NBA
    int n_found      = 0;
    int n_dropped    = 0;   // appends to a full list
    int n_errors     = 0;
    bit drain_next   = 1'b0;

    // Apply one accepted command to the list model; fetches queue a pick.
    task automatic apply_command(input t_cmd_item it);
        int                        best_idx;
        logic [MOVE_W-1:0]         tmp_move;
        logic signed [SCORE_W-1:0] tmp_score;
        t_pick                     res;
        case (it.cmd)
            CMD_APPEND: begin
                if (list_len < MAX_ENTRIES) begin
                    list_move[list_len]  = it.move;
                    list_score[list_len] = it.score;
                    list_len++;
                end else begin
                    n_dropped++;            // full list: entry is lost
                end
            end
            CMD_CLEAR: begin
                list_len = 0;               // stored entries stay but are dead
            end
            CMD_FETCH: begin
                n_fetch_acc++;
                if (it.position >= list_len) begin
                    res = '{move: '0, found: 1'b0};
                end else begin
                    // first highest wins: only a strictly greater score moves it
                    best_idx = it.position;
                    for (int i = it.position + 1; i < list_len; i++) begin
                        if (list_score[i] > list_score[best_idx]) best_idx = i;
                    end
                    tmp_move                 = list_move[best_idx];
                    tmp_score                = list_score[best_idx];
                    list_move[best_idx]      = list_move[it.position];
                    list_score[best_idx]     = list_score[it.position];
                    list_move[it.position]   = tmp_move;
                    list_score[it.position]  = tmp_score;
                    res = '{move: tmp_move, found: 1'b1};
                end
                expected_picks.push_back(res);
            end
            default: ;                      // unused code: no effect
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Planning helpers
    // ------------------------------------------------------------------------
    task automatic add_item(input logic [CMD_W-1:0] cmd, input int move,
                            input logic signed [SCORE_W-1:0] score, input int position);
        t_cmd_item it;
        it.cmd      = cmd;
        it.move     = move[MOVE_W-1:0];
        it.score    = score;
        it.position = position[POS_W-1:0];
        it.drain    = drain_next;
        drain_next  = 1'b0;
        cmd_backlog.push_back(it);
        if (cmd != CMD_UNUSED) n_planned++;
    endtask

    function automatic logic signed [SCORE_W-1:0] pick_score(input t_score_style style);
        logic signed [SCORE_W-1:0] s;
        case (style)
            SC_WIDE: s = $urandom;
            SC_TIES: s = int'($urandom_range(0, 6)) - 3;  // many equal scores
            default: begin
                case ($urandom_range(0, 4))
                    0:       s = 32'sh7fff_ffff;
                    1:       s = 32'sh8000_0000;
                    2:       s = 0;
                    3:       s = -1;
                    default: s = 1;
                endcase
            end
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: bursts of transactions separated by random gaps. A drain item
    // is held back until every outstanding pick has come out.
    // ------------------------------------------------------------------------
    t_cmd_item cur_item;
    int        burst_left = 4;
    int        gap_left   = 0;

    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                apply_command(cur_item);
                n_sent++;
                offer = 1'b0;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    // a third of the bursts follow on with no gap at all
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_backlog.size() != 0 &&
                             !(cmd_backlog[0].drain && n_fetch_acc != n_res_seen)) begin
                    cur_item = cmd_backlog.pop_front();
                    offer    = 1'b1;
                end
            end
            // valid stays high until the transaction goes through
            s_axis_tvalid <= offer;
            s_axis_tdata  <= {4'b0000, cur_item.position, cur_item.score, cur_item.move};
            s_axis_tuser  <= cur_item.cmd;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: its own ready pattern, switching between open, busy and
    // choked stretches, plus two long hold-offs once enough picks are seen.
    // ------------------------------------------------------------------------
    t_rx_mode rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;
    int       n_holds   = 0;

    always @(posedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if ((n_holds == 0 && n_res_seen >= 60) ||
                         (n_holds == 1 && n_res_seen >= 250)) begin
                // sender keeps going: block fills and stalls its input
                hold_left = HOLD_CYCLES;
                n_holds++;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN: rdy = 1'b1;
                    RX_BUSY: rdy = ($urandom_range(0, 9) < 7);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted result against the oldest predicted pick
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_res_seen <= n_res_seen + 1;
            if (expected_picks.size() == 0) begin
                $display("%0t: result with nothing expected: tdata=%h tuser=%b",
                         $time, m_axis_tdata, m_axis_tuser);
                n_errors++;
            end else begin
                want = expected_picks.pop_front();
                if (want.found) n_found++;
                if (m_axis_tuser !== want.found) begin
                    $display("%0t: found mismatch: expected %b, actual %b",
                             $time, want.found, m_axis_tuser);
                    n_errors++;
                end
                // pad bits must read zero along with the move
                if (m_axis_tdata !== {2'b00, want.move}) begin
                    $display("%0t: best_move mismatch: expected %h, actual %h",
                             $time, {2'b00, want.move}, m_axis_tdata);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout after %0d cycles, %0d commands left, %0d picks owed",
                 $time, cycle_cnt, cmd_backlog.size(), expected_picks.size());
        $display("partial_selection_sort_max_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus plan and end of run
    // ------------------------------------------------------------------------
    initial begin
        int           n_appends;
        int           n_live;
        int           n_fetches;
        int           n_noise;
        int           r;
        bit           mid_drain_done;
        t_score_style style;

        mid_drain_done = 1'b0;

        // directed: empty list, unused code, extreme scores, ties, misses
        add_item(CMD_FETCH,  0, 0, 0);                  // fetch on empty list
        add_item(CMD_UNUSED, 63, -1, 32);               // ignored code, move and score all ones
        add_item(CMD_APPEND, 63, 32'sh7fff_ffff, 0);
        add_item(CMD_APPEND, 0,  32'sh8000_0000, 63);
        add_item(CMD_APPEND, 21, -1, 0);
        add_item(CMD_APPEND, 42, 32'sh7fff_ffff, 0);    // ties with the first
        add_item(CMD_APPEND, 5,  0, 0);
        add_item(CMD_FETCH,  0, 0, 0);                  // first of the tied max
        add_item(CMD_FETCH,  0, 0, 1);                  // the other max
        add_item(CMD_FETCH,  0, 0, 5);                  // position == count
        add_item(CMD_FETCH,  0, 0, 32);                 // past the list depth
        add_item(CMD_FETCH,  0, 0, 4);                  // last entry alone
        drain_next = 1'b1;                              // sender waits here
        add_item(CMD_CLEAR,  0, 0, 0);
        add_item(CMD_FETCH,  0, 0, 0);                  // after clear: miss
        add_item(CMD_APPEND, 7, 1, 0);
        add_item(CMD_FETCH,  0, 0, 0);

        // random: mostly full sort passes over fresh lists, some noise
        while (n_planned < ITEM_TARGET) begin
            if (!mid_drain_done && n_planned >= ITEM_TARGET / 2) begin
                drain_next     = 1'b1;
                mid_drain_done = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
                style     = t_score_style'($urandom_range(0, 2));
                // mostly short lists; some fill it and overflow
                n_appends = ($urandom_range(0, 6) == 0) ? $urandom_range(28, 34)
                                                        : $urandom_range(1, 12);
                add_item(CMD_CLEAR, $urandom_range(0, 63), $urandom, $urandom_range(0, 32));
                for (int i = 0; i < n_appends; i++) begin
                    add_item(CMD_APPEND, $urandom_range(0, 63), pick_score(style),
                             $urandom_range(0, 32));
                end
                n_live    = (n_appends < MAX_ENTRIES) ? n_appends : MAX_ENTRIES;
                n_fetches = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_live) : n_live;
                for (int p = 0; p < n_fetches; p++) begin
                    add_item(CMD_FETCH, $urandom_range(0, 63), $urandom, p);
                    if ($urandom_range(0, 9) == 0) begin
                        add_item(CMD_FETCH, $urandom_range(0, 63), $urandom,
                                 $urandom_range(0, 32));
                    end
                end
                if ($urandom_range(0, 1) == 0) begin
                    add_item(CMD_FETCH, 0, 0, ($urandom_range(0, 1) == 0) ? n_live : 32);
                end
            end else begin
                n_noise = $urandom_range(1, 6);
                for (int i = 0; i < n_noise; i++) begin
                    r = $urandom_range(0, 9);
                    add_item((r < 4) ? CMD_APPEND : (r == 4) ? CMD_CLEAR :
                             (r < 9) ? CMD_FETCH : CMD_UNUSED,
                             $urandom_range(0, 63), pick_score(SC_WIDE),
                             $urandom_range(0, 32));
                end
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all stimulus accepted, then all picks back, then a quiet tail
        while (cmd_backlog.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (n_fetch_acc != n_res_seen) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d commands, %0d fetches checked (%0d found, %0d null), %0d cycles",
                 n_sent, n_res_seen, n_found, n_res_seen - n_found, cycle_cnt);
        $display("run: %0d appends to a full list, %0d long output hold-offs, %0d mismatches",
                 n_dropped, n_holds, n_errors);
        if (n_errors == 0 && expected_picks.size() == 0) begin
            $display("partial_selection_sort_max_tb: clean");
        end else begin
            $display("partial_selection_sort_max_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
